/* rtl/core/ptc_pkg.sv */
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int NUM_LANES   = 3;
  localparam int TABLE_DEPTH = 256;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int CHAN_W      = 8;
  localparam int SUM_W       = 2 * CHAN_W;
  localparam int CFG_AW      = 3;

  localparam logic CMD_TABLE_WRITE = 1'b0;
  localparam logic CMD_PIXEL       = 1'b1;

  localparam logic [CFG_AW-1:0] CFG_ENABLE_ADJUST = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_BLEND_ALPHA   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_TINT_RED      = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_TINT_GREEN    = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_TINT_BLUE     = 3'd4;

  typedef struct packed {
    logic                wr_en;
    logic [TABLE_AW-1:0] wr_addr;
    logic [CHAN_W-1:0]   wr_data;
    logic                en1;
    logic                en2;
  } ptc_ctl_t;

endpackage

/* rtl/core/ptc_lane.sv */
`timescale 1ns / 1ps

module ptc_lane
  import ptc_pkg::*;
(
  input  logic              clk,
  input  ptc_ctl_t          ctl,
  input  logic [CHAN_W-1:0] level,
  input  logic [CHAN_W-1:0] tint,
  input  logic [CHAN_W-1:0] alpha,
  output logic [SUM_W-1:0]  blend_sum,
  output logic [CHAN_W-1:0] raw_level
);

  logic [CHAN_W-1:0] tone_mem [TABLE_DEPTH];
  logic [CHAN_W-1:0] lut_r;
  logic [CHAN_W-1:0] raw1_r;
  logic [CHAN_W-1:0] raw2_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [SUM_W-1:0]  prod_tone;
  logic [SUM_W-1:0]  prod_tint;
  logic [CHAN_W-1:0] inv_alpha;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      tone_mem[ctl.wr_addr] <= ctl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      lut_r  <= tone_mem[level];
      raw1_r <= level;
    end
  end

  assign inv_alpha = {CHAN_W{1'b1}} - alpha;
  assign prod_tone = lut_r * inv_alpha;
  assign prod_tint = tint * alpha;
  assign sum_nxt   = prod_tone + prod_tint;

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      sum_r  <= sum_nxt;
      raw2_r <= raw1_r;
    end
  end

  assign blend_sum = sum_r;
  assign raw_level = raw2_r;

endmodule

/* rtl/core/ptc_merge.sv */
`timescale 1ns / 1ps

module ptc_merge
  import ptc_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             adjust,
  input  logic [NUM_LANES-1:0][SUM_W-1:0]  blend_sum,
  input  logic [NUM_LANES-1:0][CHAN_W-1:0] raw_level,
  input  logic [CHAN_W-1:0]                alpha,
  input  logic                             last,
  output logic                             load_en,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata,
  output logic                             out_tlast
);

  logic                             valid_r;
  logic [NUM_LANES-1:0][CHAN_W-1:0] chan_r;
  logic [NUM_LANES-1:0][CHAN_W-1:0] chan_nxt;
  logic [CHAN_W-1:0]                alpha_r;
  logic                             last_r;

  assign load_en = !valid_r || out_tready;

  // Exact floor(x / 255) for any sum up to 255 * 255: (x + (x >> 8) + 1) >> 8.
  always_comb begin
    logic [SUM_W-1:0] t;
    for (int i = 0; i < NUM_LANES; i++) begin
      t = blend_sum[i] + {{CHAN_W{1'b0}}, blend_sum[i][SUM_W-1:CHAN_W]} + SUM_W'(1);
      chan_nxt[i] = adjust ? t[SUM_W-1:CHAN_W] : raw_level[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      chan_r  <= chan_nxt;
      alpha_r <= alpha;
      last_r  <= last;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {chan_r[2], chan_r[1], chan_r[0], alpha_r};
  assign out_tlast  = last_r;

endmodule

/* rtl/core/pixel_tone_curve_and_tint_blend.sv */
`timescale 1ns / 1ps

// Channel  Direction  Contents
// in_      slave      tdata: entry_index, entry_value, pixel_alpha, pixel_red,
//                     pixel_green, pixel_blue; tuser: command; tlast: last_in
// out_     master     tdata: out_alpha, out_red, out_green, out_blue; tlast: last_out
// cfg_     write      enable_adjust, blend_alpha, tint_red, tint_green, tint_blue
//
// One beat per clock while in_tready is high; lookup, blend, output are registered.
// Three colour lanes each hold a copy of the tone table, so all three lookups
// share one cycle. Table writes give no output beat.
// Reset clears configuration and pipeline valid flags; the table is not cleared.
// A stalled output only holds back the input once the pipeline stages are full.

module pixel_tone_curve_and_tint_blend
  import ptc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // entry_index, entry_value, pixel_alpha, pixel_red, pixel_green, pixel_blue
  input  logic [47:0]       in_tdata,
  // command
  input  logic              in_tuser,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  // out_alpha, out_red, out_green, out_blue
  output logic [31:0]       out_tdata,
  output logic              out_tlast,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CHAN_W-1:0] cfg_wdata
);

  logic                             enable_r;
  logic [CHAN_W-1:0]                alpha_cfg_r;
  logic [NUM_LANES-1:0][CHAN_W-1:0] tint_r;

  logic                             v1_r;
  logic                             v2_r;
  logic [CHAN_W-1:0]                pa1_r;
  logic [CHAN_W-1:0]                pa2_r;
  logic                             last1_r;
  logic                             last2_r;

  logic                             en1;
  logic                             en2;
  logic                             en3;
  logic                             in_fire;
  ptc_ctl_t                         ctl;
  logic [NUM_LANES-1:0][CHAN_W-1:0] level;
  logic [NUM_LANES-1:0][SUM_W-1:0]  blend_sum;
  logic [NUM_LANES-1:0][CHAN_W-1:0] raw_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      alpha_cfg_r <= '0;
      tint_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ENABLE_ADJUST: enable_r    <= cfg_wdata[0];
        CFG_BLEND_ALPHA:   alpha_cfg_r <= cfg_wdata;
        CFG_TINT_RED:      tint_r[0]   <= cfg_wdata;
        CFG_TINT_GREEN:    tint_r[1]   <= cfg_wdata;
        CFG_TINT_BLUE:     tint_r[2]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;
  assign in_fire   = in_tvalid && in_tready;

  assign ctl.wr_en   = in_fire && (in_tuser == CMD_TABLE_WRITE);
  assign ctl.wr_addr = in_tdata[7:0];
  assign ctl.wr_data = in_tdata[15:8];
  assign ctl.en1     = en1;
  assign ctl.en2     = en2;

  assign level[0] = in_tdata[31:24];
  assign level[1] = in_tdata[39:32];
  assign level[2] = in_tdata[47:40];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_fire && (in_tuser == CMD_PIXEL);
      end
      if (en2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pa1_r   <= in_tdata[23:16];
      last1_r <= in_tlast;
    end
    if (en2) begin
      pa2_r   <= pa1_r;
      last2_r <= last1_r;
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    ptc_lane u_lane (
      .clk       (clk),
      .ctl       (ctl),
      .level     (level[g]),
      .tint      (tint_r[g]),
      .alpha     (alpha_cfg_r),
      .blend_sum (blend_sum[g]),
      .raw_level (raw_level[g])
    );
  end

  ptc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (v2_r),
    .adjust     (enable_r),
    .blend_sum  (blend_sum),
    .raw_level  (raw_level),
    .alpha      (pa2_r),
    .last       (last2_r),
    .load_en    (en3),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
